>>> hdl/tdp_pkg.sv
`timescale 1ns / 1ps

package tdp_pkg;

    // fixed field widths
    localparam int DELAY_W   = 23;
    localparam int WRAPS_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    // timer clock in MHz
    localparam int CLOCK_MHZ = 8;

    // fraction bits of the reciprocal used to divide by the clock
    localparam int TICK_FRAC_W = 16;

    // shared divider: 32 by 16 bits, four quotient bits per cycle
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_STEPS  = DIVIDEND_W / 4;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // compare-match divisor search start
    localparam logic [BYTE_W-1:0] DIV_START   = 8'hFF;
    localparam logic [BYTE_W-1:0] COMPARE_FULL = 8'hFF;
    localparam logic [BYTE_W-1:0] COUNTER_BIAS = 8'd2;
    localparam int MS_TO_US = 1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSTSCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER  = 2'd3;

    // timing modes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_COMPARE = 2'd1;

    // item kinds on the input tuser
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_INTR  = 1'b1;

    // result kinds written by a commit
    localparam logic [1:0] KIND_ERR     = 2'd0;
    localparam logic [1:0] KIND_INTR    = 2'd1;
    localparam logic [1:0] KIND_NORMAL  = 2'd2;
    localparam logic [1:0] KIND_COMPARE = 2'd3;

    // divider operand selection
    localparam logic [1:0] SRC_TOTAL = 2'd1;
    localparam logic [1:0] SRC_FIRST = 2'd2;
    localparam logic [1:0] SRC_NEXT  = 2'd3;

    typedef struct packed {
        logic       latch_in;
        logic       start_div;
        logic [1:0] div_src;
        logic       save_total;
        logic       commit;
        logic [1:0] kind;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic mode_bad;
        logic mode_cmp;
        logic div_busy;
        logic div_done;
        logic tick_zero;
        logic rem_zero;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [WRAPS_W-1:0] wraps_needed;
        logic               fire;
        logic [BYTE_W-1:0]  compare_write_value;
        logic               compare_write_valid;
        logic [BYTE_W-1:0]  counter_write_value;
        logic               counter_write_valid;
        logic               status;
    } res_t;

endpackage

>>> hdl/tdp_div.sv
`timescale 1ns / 1ps

module tdp_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tdp_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [tdp_pkg::DIVISOR_W-1:0]     divisor,
    output logic                              busy,
    output logic                              done,
    output logic [tdp_pkg::DIVIDEND_W-1:0]    quotient,
    output logic [tdp_pkg::DIVISOR_W-1:0]     remainder
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [tdp_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [tdp_pkg::DIVIDEND_W-1:0]   quot_reg;
    logic [tdp_pkg::DIVIDEND_W-1:0]   quot_next;
    logic [tdp_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [tdp_pkg::DIVISOR_W-1:0]    rem_next;
    logic [tdp_pkg::DIVISOR_W-1:0]    dsr_reg;

    // four restoring steps per cycle, dividend shifts out as quotient shifts in
    always_comb
    begin
        logic [tdp_pkg::DIVISOR_W:0]     r;
        logic [tdp_pkg::DIVIDEND_W-1:0]  q;
        r = {1'b0, rem_reg};
        q = quot_reg;
        for (int i = 0; i < 4; i++)
        begin
            r = {r[tdp_pkg::DIVISOR_W-1:0], q[tdp_pkg::DIVIDEND_W-1]};
            q = {q[tdp_pkg::DIVIDEND_W-2:0], 1'b0};
            if (r >= {1'b0, dsr_reg})
            begin
                r    = r - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
        end
        rem_next  = r[tdp_pkg::DIVISOR_W-1:0];
        quot_next = q;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + tdp_pkg::DIV_CNT_W'(1);
                if (cnt_reg == tdp_pkg::DIV_CNT_W'(tdp_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/tdp_ctrl.sv
`timescale 1ns / 1ps

module tdp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tdp_pkg::stat_t stat,
    output tdp_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_DISPATCH    = 3'd1;
    localparam logic [2:0] ST_WAIT_TOTAL  = 3'd3;
    localparam logic [2:0] ST_WAIT_SEARCH = 3'd4;
    localparam logic [2:0] ST_COMMIT      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (stat.func == tdp_pkg::FUNC_INTR)
                begin
                    kind_next  = tdp_pkg::KIND_INTR;
                    state_next = ST_COMMIT;
                end
                else if (stat.mode_bad)
                begin
                    kind_next  = tdp_pkg::KIND_ERR;
                    state_next = ST_COMMIT;
                end
                else if (stat.tick_zero)
                begin
                    kind_next  = tdp_pkg::KIND_ERR;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    cmd.div_src   = tdp_pkg::SRC_TOTAL;
                    state_next    = ST_WAIT_TOTAL;
                end
            end
            ST_WAIT_TOTAL:
            begin
                if (stat.div_done)
                begin
                    cmd.save_total = 1'b1;
                    if (stat.mode_cmp)
                    begin
                        cmd.start_div = 1'b1;
                        cmd.div_src   = tdp_pkg::SRC_FIRST;
                        state_next    = ST_WAIT_SEARCH;
                    end
                    else
                    begin
                        kind_next  = tdp_pkg::KIND_NORMAL;
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_WAIT_SEARCH:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        kind_next  = tdp_pkg::KIND_COMPARE;
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        cmd.start_div = 1'b1;
                        cmd.div_src   = tdp_pkg::SRC_NEXT;
                    end
                end
            end
            ST_COMMIT:
            begin
                cmd.kind = kind_reg;
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= tdp_pkg::KIND_ERR;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> hdl/tdp_datapath.sv
`timescale 1ns / 1ps

module tdp_datapath
#(
    parameter int CLOCK_MHZ = tdp_pkg::CLOCK_MHZ
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tdp_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [tdp_pkg::CFG_DAT_W-1:0]   cfg_dat,
    input  logic                            in_func,
    input  logic [tdp_pkg::DELAY_W-1:0]     in_delay,
    input  tdp_pkg::cmd_t                   cmd,
    output tdp_pkg::stat_t                  stat,
    input  logic                            out_ready,
    output logic                            out_valid,
    output tdp_pkg::res_t                   out_res
);

    // rounded-up reciprocal of the clock, exact for numerators up to 1024
    localparam int TICK_RECIP = ((1 << tdp_pkg::TICK_FRAC_W) + CLOCK_MHZ - 1) / CLOCK_MHZ;

    // configuration
    logic [1:0] prescale_reg;
    logic [3:0] postscale_reg;
    logic [1:0] mode_reg;
    logic       handler_reg;

    // item and working values
    logic                             func_reg;
    logic [tdp_pkg::DIVIDEND_W-1:0]   prod_reg;
    logic [tdp_pkg::DIVIDEND_W-1:0]   total_reg;
    logic [tdp_pkg::BYTE_W-1:0]       div_reg;

    // planner state
    logic [tdp_pkg::WRAPS_W-1:0] req_reg;
    logic [tdp_pkg::WRAPS_W-1:0] req_next;
    logic [tdp_pkg::BYTE_W-1:0]  reload_reg;
    logic [tdp_pkg::BYTE_W-1:0]  reload_next;
    logic [tdp_pkg::WRAPS_W-1:0] icnt_reg;
    logic [tdp_pkg::WRAPS_W-1:0] icnt_next;

    // output register
    logic          out_valid_reg;
    tdp_pkg::res_t res_reg;
    tdp_pkg::res_t res_next;

    // divider connections
    logic [tdp_pkg::DIVIDEND_W-1:0] dvd;
    logic [tdp_pkg::DIVISOR_W-1:0]  dsr;
    logic                           div_busy;
    logic                           div_done;
    logic [tdp_pkg::DIVIDEND_W-1:0] div_quot;
    logic [tdp_pkg::DIVISOR_W-1:0]  div_rem;

    logic [4:0]                     post_p1;
    logic [2:0]                     pre_shift;
    logic [10:0]                    tick_num;
    logic [27:0]                    tick_prod;
    logic [10:0]                    tick_val;
    logic [tdp_pkg::DIVIDEND_W-1:0] prod_full;
    logic [tdp_pkg::BYTE_W-1:0]     div_dec;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= '0;
            postscale_reg <= '0;
            mode_reg      <= '0;
            handler_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tdp_pkg::CFG_PRESCALE:  prescale_reg  <= cfg_dat[1:0];
                tdp_pkg::CFG_POSTSCALE: postscale_reg <= cfg_dat;
                tdp_pkg::CFG_MODE:      mode_reg      <= cfg_dat[1:0];
                tdp_pkg::CFG_HANDLER:   handler_reg   <= cfg_dat[0];
                default:                ;
            endcase
        end
    end

    // tick numerator: prescaler * (postscale + 1) * 4, prescaler is a power of two
    assign post_p1   = {1'b0, postscale_reg} + 5'd1;
    assign pre_shift = (prescale_reg == 2'd0) ? 3'd2 : ({1'b0, prescale_reg} + 3'd3);
    assign tick_num  = 11'(post_p1) << pre_shift;

    // tick time in us: numerator over the clock, by reciprocal multiplication
    assign tick_prod = 28'(tick_num) * 28'(TICK_RECIP);
    assign tick_val  = tick_prod[tdp_pkg::TICK_FRAC_W+10:tdp_pkg::TICK_FRAC_W];

    // delay in microseconds, wraps at 32 bits
    assign prod_full = {{(tdp_pkg::DIVIDEND_W - tdp_pkg::DELAY_W){1'b0}}, in_delay}
                       * tdp_pkg::DIVIDEND_W'(tdp_pkg::MS_TO_US);

    assign div_dec = div_reg - 8'd1;

    // divider operand select
    always_comb
    begin
        unique case (cmd.div_src)
            tdp_pkg::SRC_TOTAL:
            begin
                dvd = prod_reg;
                dsr = tdp_pkg::DIVISOR_W'(tick_val);
            end
            tdp_pkg::SRC_FIRST:
            begin
                dvd = div_quot;
                dsr = tdp_pkg::DIVISOR_W'(tdp_pkg::DIV_START);
            end
            default:
            begin
                dvd = total_reg;
                dsr = tdp_pkg::DIVISOR_W'(div_dec);
            end
        endcase
    end

    tdp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_div),
        .dividend  (dvd),
        .divisor   (dsr),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg <= in_func;
            prod_reg <= prod_full;
        end
        if (cmd.save_total)
        begin
            total_reg <= div_quot;
        end
        if (cmd.start_div && cmd.div_src == tdp_pkg::SRC_FIRST)
        begin
            div_reg <= tdp_pkg::DIV_START;
        end
        else if (cmd.start_div && cmd.div_src == tdp_pkg::SRC_NEXT)
        begin
            div_reg <= div_dec;
        end
    end

    // result and state update at commit
    always_comb
    begin
        req_next    = req_reg;
        reload_next = reload_reg;
        icnt_next   = icnt_reg;
        res_next    = '0;
        unique case (cmd.kind)
            tdp_pkg::KIND_ERR:
            begin
                res_next.status = 1'b1;
            end
            tdp_pkg::KIND_INTR:
            begin
                if (handler_reg)
                begin
                    icnt_next = icnt_reg + 16'd1;
                    if (icnt_reg == req_reg)
                    begin
                        icnt_next                    = '0;
                        res_next.counter_write_valid = 1'b1;
                        res_next.counter_write_value = reload_reg + tdp_pkg::COUNTER_BIAS;
                        res_next.fire                = 1'b1;
                    end
                end
            end
            tdp_pkg::KIND_NORMAL:
            begin
                req_next    = total_reg[tdp_pkg::WRAPS_W+7:8];
                reload_next = 8'd0 - total_reg[7:0];
                res_next.counter_write_valid = 1'b1;
                res_next.counter_write_value = reload_next + tdp_pkg::COUNTER_BIAS;
                res_next.compare_write_valid = 1'b1;
                res_next.compare_write_value = tdp_pkg::COMPARE_FULL;
            end
            default:
            begin
                req_next    = div_quot[tdp_pkg::WRAPS_W-1:0];
                reload_next = div_dec;
                res_next.counter_write_valid = 1'b1;
                res_next.counter_write_value = tdp_pkg::COUNTER_BIAS;
                res_next.compare_write_valid = 1'b1;
                res_next.compare_write_value = div_dec;
            end
        endcase
        res_next.wraps_needed = req_next;
    end

    // planner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg    <= '0;
            reload_reg <= '0;
            icnt_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            req_reg    <= req_next;
            reload_reg <= reload_next;
            icnt_reg   <= icnt_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    // status to the controller
    assign stat.func      = func_reg;
    assign stat.mode_bad  = (mode_reg != tdp_pkg::MODE_NORMAL)
                            && (mode_reg != tdp_pkg::MODE_COMPARE);
    assign stat.mode_cmp  = (mode_reg == tdp_pkg::MODE_COMPARE);
    assign stat.div_busy  = div_busy;
    assign stat.div_done  = div_done;
    assign stat.tick_zero = (tick_val == '0);
    assign stat.rem_zero  = (div_rem == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

>>> hdl/timer_delay_planner_core.sv
`timescale 1ns / 1ps

// Timer delay planner: one result per input transaction, in order. The tick time
// comes from the prescaler, postscaler and clock in the same cycle by a reciprocal
// multiplication. An interrupt transaction or a rejected start goes from dispatch
// straight to commit. A start in normal mode needs one pass of the shared radix-16
// divider (total ticks) before its commit. In compare-match mode the same divider
// then tests divisors from 255 downward, one pass per divisor, until one divides
// the total. One transaction is in work at a time; a finished result waits in the
// output register while the next transaction is accepted, and a result still held
// there stalls the commit of the next one.
// Configuration writes are always ready.

module timer_delay_planner_core
#(
    parameter int CLOCK_MHZ = tdp_pkg::CLOCK_MHZ
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // delay[22:0], zero pad
    input  logic                              s_tuser,  // func
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, counter_write_valid, counter_write_value[7:0], compare_write_valid,
    // compare_write_value[7:0], fire, wraps_needed[15:0], zero pad
    output logic [39:0]                       m_tdata,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdp_pkg::CFG_DAT_W-1:0]     cfg_data
);

    tdp_pkg::cmd_t  cmd;
    tdp_pkg::stat_t stat;
    tdp_pkg::res_t  res;

    assign cfg_ready = 1'b1;

    tdp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tdp_datapath
    #(
        .CLOCK_MHZ (CLOCK_MHZ)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_dat   (cfg_data),
        .in_func   (s_tuser),
        .in_delay  (s_tdata[tdp_pkg::DELAY_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    // result packing, lowest field first
    assign m_tdata = {4'b0, res};

`ifndef SYNTHESIS
    // an accepted transaction takes the controller out of idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // a commit never overwrites a result that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("commit into a full output register");

    // the divider is only started when idle
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |-> !stat.div_busy)
        else $error("divider restarted while busy");

    // a commit shows up as a valid result next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");
`endif

endmodule

>>> tb/timer_delay_planner_core_tb.sv
`timescale 1ns / 1ps

module timer_delay_planner_core_tb;

    localparam int         HALF_PERIOD   = 6;
    localparam int         RESET_CYCLES  = 7;
    localparam longint     CYCLE_LIMIT   = 40_000_000;
    localparam int         SETTLE_CYCLES = 50;
    localparam int         MAX_REPORTS   = 10;
    localparam int         DELAY_MAX     = 4294967;
    localparam int         IRQ_CAP       = 40;
    localparam int         AIM_SPAN      = 20;
    localparam logic [1:0] MODE_BAD_LO   = 2'd2;
    localparam logic [1:0] MODE_BAD_HI   = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [23:0]                   s_tdata;   // delay[22:0], zero pad
    logic                          s_tuser;   // func
    logic                          m_tvalid;
    logic                          m_tready;
    // status, counter_write_valid, counter_write_value[7:0], compare_write_valid,
    // compare_write_value[7:0], fire, wraps_needed[15:0], zero pad
    logic [39:0]                   m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tdp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tdp_pkg::CFG_DAT_W-1:0] cfg_data;

    // shadow settings and timer state
    logic [1:0]  cfg_pre_code = '0;
    logic [3:0]  cfg_post     = '0;
    logic [1:0]  cfg_mode     = '0;
    logic        cfg_handler  = 1'b0;
    logic [15:0] req_count    = '0;
    logic [7:0]  preload      = '0;
    logic [15:0] irq_count    = '0;

    tdp_pkg::res_t planned_q[$];
    int     mismatches   = 0;
    int     items_sent   = 0;
    int     gap_pct      = 0;
    int     rdy_idle_pct = 0;
    int     hold_request = 0;
    int     hold_left    = 0;
    longint cycle_count  = 0;

    timer_delay_planner_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // tick time in us from the prescaler, postscaler and clock
    function automatic logic [15:0] tick_us();
        logic [31:0] pre;
        logic [31:0] scaled;
        pre    = (cfg_pre_code == 2'd0) ? 32'd1 : (32'd2 << cfg_pre_code);
        scaled = (pre * (32'(cfg_post) + 32'd1) * 32'd4) / 32'(tdp_pkg::CLOCK_MHZ);
        return scaled[15:0];
    endfunction

    // wrap count and preload a start would set; needs a valid mode and nonzero tick
    function automatic void derive_plan(input logic [22:0] delay_val,
                                        output logic [15:0] wraps, output logic [7:0] load);
        logic [31:0] us;
        logic [31:0] total;
        logic [31:0] divisor;
        us    = 32'(delay_val) * 32'(tdp_pkg::MS_TO_US);
        total = us / 32'(tick_us());
        if (cfg_mode == tdp_pkg::MODE_NORMAL)
        begin
            wraps = total[23:8];
            load  = 8'd0 - total[7:0];
        end
        else
        begin
            // largest divisor not above 255
            divisor = 32'(tdp_pkg::DIV_START);
            while ((total % divisor) != 0)
                divisor--;
            wraps = 16'(total / divisor);
            load  = divisor[7:0] - 8'd1;
        end
    endfunction

    // expected result of one item, advancing the shadow state
    function automatic tdp_pkg::res_t plan_item(input logic func, input logic [22:0] delay_val);
        tdp_pkg::res_t r;
        logic [15:0]   prior;
        r = '0;
        if (func == tdp_pkg::FUNC_START)
        begin
            if (cfg_mode == MODE_BAD_LO || cfg_mode == MODE_BAD_HI || tick_us() == 16'd0)
                r.status = 1'b1;
            else
            begin
                derive_plan(delay_val, req_count, preload);
                r.counter_write_valid = 1'b1;
                r.compare_write_valid = 1'b1;
                if (cfg_mode == tdp_pkg::MODE_NORMAL)
                begin
                    r.counter_write_value = preload + tdp_pkg::COUNTER_BIAS;
                    r.compare_write_value = tdp_pkg::COMPARE_FULL;
                end
                else
                begin
                    r.counter_write_value = tdp_pkg::COUNTER_BIAS;
                    r.compare_write_value = preload;
                end
            end
        end
        else if (cfg_handler)
        begin
            prior     = irq_count;
            irq_count = irq_count + 16'd1;
            if (prior == req_count)
            begin
                r.counter_write_valid = 1'b1;
                r.counter_write_value = preload + tdp_pkg::COUNTER_BIAS;
                r.fire                = 1'b1;
                irq_count             = '0;
            end
        end
        r.wraps_needed = req_count;
        return r;
    endfunction

    function automatic logic [22:0] random_delay();
        if ($urandom_range(0, 1))
            return 23'($urandom_range(0, DELAY_MAX));
        return 23'($urandom_range(0, 400));
    endfunction

    // delay whose wrap count sits just at or above the current interrupt count
    function automatic logic [22:0] aimed_delay();
        logic [15:0] tick;
        logic [15:0] wraps;
        logic [7:0]  load;
        logic [31:0] base;
        logic [22:0] dly;
        tick = tick_us();
        if (tick == 16'd0 || cfg_mode == MODE_BAD_LO || cfg_mode == MODE_BAD_HI)
            return 23'($urandom_range(0, 400));
        base = ((32'(irq_count) + $urandom_range(0, 8)) * 32'd256 * 32'(tick)) / 32'd1000;
        for (int i = 0; i < 64; i++)
        begin
            dly = 23'(base + i);
            derive_plan(dly, wraps, load);
            if (wraps >= irq_count && 32'(wraps) <= 32'(irq_count) + AIM_SPAN)
                return dly;
        end
        return 23'($urandom_range(0, 32'(tick) * 5 + 1));
    endfunction

    // one input transaction; returns its expected result
    task automatic send_item(input logic func, input logic [22:0] delay_val,
                             output tdp_pkg::res_t planned);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, delay_val};
        do
            @(posedge clk);
        while (!s_tready);
        planned = plan_item(func, delay_val);
        planned_q.push_back(planned);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (planned_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tdp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tdp_pkg::CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tdp_pkg::CFG_PRESCALE:  cfg_pre_code = value[1:0];
            tdp_pkg::CFG_POSTSCALE: cfg_post     = value;
            tdp_pkg::CFG_MODE:      cfg_mode     = value[1:0];
            tdp_pkg::CFG_HANDLER:   cfg_handler  = value[0];
        endcase
    endtask

    // all four registers, only once the block is idle
    task automatic set_config(input logic [1:0] pre_code, input logic [3:0] post,
                              input logic [1:0] mode, input logic handler);
        wait_drain();
        write_reg(tdp_pkg::CFG_PRESCALE, tdp_pkg::CFG_DAT_W'(pre_code));
        write_reg(tdp_pkg::CFG_POSTSCALE, post);
        write_reg(tdp_pkg::CFG_MODE, tdp_pkg::CFG_DAT_W'(mode));
        write_reg(tdp_pkg::CFG_HANDLER, tdp_pkg::CFG_DAT_W'(handler));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver ready, with an optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rdy_idle_pct);
        end
    end

    // compare each output transaction with the oldest expected one
    always @(posedge clk)
    begin : result_check
        tdp_pkg::res_t got;
        tdp_pkg::res_t want;
        got = m_tdata[$bits(tdp_pkg::res_t)-1:0];
        if (rst_n && m_tvalid && m_tready)
        begin
            if (planned_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transaction: data %h", m_tdata);
            end
            else
            begin
                want = planned_q.pop_front();
                if (got.status !== want.status
                    || got.counter_write_valid !== want.counter_write_valid
                    || got.counter_write_value !== want.counter_write_value
                    || got.compare_write_valid !== want.compare_write_valid
                    || got.compare_write_value !== want.compare_write_value
                    || got.fire !== want.fire
                    || got.wraps_needed !== want.wraps_needed)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch: exp st=%0d cw=%0d/%0d kw=%0d/%0d fire=%0d wraps=%0d",
                                 want.status, want.counter_write_valid,
                                 want.counter_write_value, want.compare_write_valid,
                                 want.compare_write_value, want.fire, want.wraps_needed);
                        $display("          got st=%0d cw=%0d/%0d kw=%0d/%0d fire=%0d wraps=%0d",
                                 got.status, got.counter_write_valid,
                                 got.counter_write_value, got.compare_write_valid,
                                 got.compare_write_value, got.fire, got.wraps_needed);
                    end
                end
            end
        end
    end

    // field extremes, both modes, refusals and firing
    task automatic test_directed();
        tdp_pkg::res_t r;
        gap_pct      = 0;
        rdy_idle_pct = 0;
        // reset settings give a zero tick time
        send_item(tdp_pkg::FUNC_START, 23'd5, r);
        // no handler installed
        send_item(tdp_pkg::FUNC_INTR, 23'd0, r);
        // 1 us tick, normal wrap mode
        set_config(2'd0, 4'd1, tdp_pkg::MODE_NORMAL, 1'b1);
        send_item(tdp_pkg::FUNC_START, 23'd0, r);
        send_item(tdp_pkg::FUNC_INTR, 23'(DELAY_MAX), r);
        send_item(tdp_pkg::FUNC_START, 23'(DELAY_MAX), r);
        send_item(tdp_pkg::FUNC_START, 23'd1, r);
        repeat (4) send_item(tdp_pkg::FUNC_INTR, 23'd0, r);
        send_item(tdp_pkg::FUNC_START, 23'h2AAAAA, r);
        send_item(tdp_pkg::FUNC_START, 23'h155555, r);
        // prescale code 2 with the largest postscale, compare match mode
        set_config(2'd2, 4'd15, tdp_pkg::MODE_COMPARE, 1'b1);
        send_item(tdp_pkg::FUNC_START, 23'd0, r);
        send_item(tdp_pkg::FUNC_INTR, 23'd0, r);
        send_item(tdp_pkg::FUNC_START, 23'd17, r);
        send_item(tdp_pkg::FUNC_START, 23'(DELAY_MAX), r);
        // invalid modes leave the plan alone
        set_config(2'd1, 4'd7, MODE_BAD_LO, 1'b1);
        send_item(tdp_pkg::FUNC_START, 23'd3, r);
        send_item(tdp_pkg::FUNC_INTR, 23'd0, r);
        set_config(2'd1, 4'd7, MODE_BAD_HI, 1'b0);
        send_item(tdp_pkg::FUNC_START, 23'd3, r);
        send_item(tdp_pkg::FUNC_INTR, 23'd0, r);
    endtask

    // random settings, mostly plan-then-count-to-fire sequences
    task automatic test_random(input int n_items, input int send_idle, input int recv_idle);
        tdp_pkg::res_t r;
        int            first;
        int            block_end;
        int            pick;
        int            k;
        gap_pct      = send_idle;
        rdy_idle_pct = recv_idle;
        first        = items_sent;
        while (items_sent - first < n_items)
        begin
            set_config(2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)),
                       ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                   : 2'($urandom_range(0, 1)),
                       $urandom_range(0, 99) < 85);
            block_end = items_sent + 30 + $urandom_range(0, 30);
            while (items_sent < block_end && items_sent - first < n_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    // plan a delay, then interrupts until it fires
                    send_item(tdp_pkg::FUNC_START, aimed_delay(), r);
                    k = 0;
                    do
                    begin
                        send_item(tdp_pkg::FUNC_INTR, random_delay(), r);
                        k++;
                    end
                    while (!r.fire && k < IRQ_CAP);
                end
                else if (pick < 90)
                    send_item(1'($urandom_range(0, 1)), random_delay(), r);
                else
                begin
                    // a plan cut short by another start
                    send_item(tdp_pkg::FUNC_START, aimed_delay(), r);
                    repeat ($urandom_range(0, 3))
                        send_item(tdp_pkg::FUNC_INTR, random_delay(), r);
                    send_item(tdp_pkg::FUNC_START, random_delay(), r);
                end
            end
        end
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        tdp_pkg::res_t r;
        set_config(2'd2, 4'd15, tdp_pkg::MODE_NORMAL, 1'b1);
        gap_pct      = 0;
        rdy_idle_pct = 0;
        hold_request = 300;
        repeat (6)
        begin
            send_item(tdp_pkg::FUNC_START, aimed_delay(), r);
            send_item(tdp_pkg::FUNC_INTR, random_delay(), r);
        end
        wait_drain();
    endtask

    // sequence of tests
    initial
    begin
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(390, 37, 88);
        test_random(390, 88, 37);
        test_backpressure();
        test_random(390, 0, 0);
        wait_drain();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
